[src/lcpd_pkg.sv]
package lcpd_pkg;

    localparam int unsigned PWM_STEPS = 4;
    localparam int unsigned PHASE_W   = $clog2(PWM_STEPS + 1);
    localparam int unsigned BRIGHT_W  = 3;
    localparam int unsigned CMP_W     = (PHASE_W > BRIGHT_W) ? PHASE_W : BRIGHT_W;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned IVAL_W    = 16;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned LED_W     = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;

    localparam logic [STEP_W-1:0] STEPS_FILL = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEPS_PAIR = STEP_W'(4);

    localparam logic [IVAL_W-1:0]   IVAL_RESET   = IVAL_W'(500);
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = BRIGHT_W'(3);

    typedef enum logic [MODE_W-1:0] {
        MODE_FILL_UP   = 2'd0,
        MODE_FILL_DOWN = 2'd1,
        MODE_CONVERGE  = 2'd2,
        MODE_DIVERGE   = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL3    = 3'd5;

    localparam logic [LED_W-1:0] LED_ALL_OFF = 8'hff;
    localparam logic [LED_W-1:0] LED_LOW     = 8'h01;
    localparam logic [LED_W-1:0] LED_HIGH    = 8'h80;
    localparam logic [LED_W-1:0] LED_MID_UP  = 8'h10;
    localparam logic [LED_W-1:0] LED_MID_DN  = 8'h08;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [PHASE_W-1:0] phase;
    } view_t;

    function automatic logic [STEP_W-1:0] steps_of(input mode_t mode);
        logic [STEP_W-1:0] n;
        n = (mode == MODE_FILL_UP || mode == MODE_FILL_DOWN) ? STEPS_FILL : STEPS_PAIR;
        return n;
    endfunction

endpackage

[src/led_chaser_pwm_dimmer.sv]
// eight-LED chaser with four chase patterns and PWM dimming, LEDs active low
// input channel: in_valid/in_ready carry one request with a tick bit
//   tick = 1 advances the interval counter and pwm phase, and the step on wrap
//   tick = 0 only refreshes the output from the current state
// output channel: out_valid/out_ready carry one led_drive byte per request
// result: registered, it shows in the cycle after acceptance
// throughput: one request per cycle while out_ready is high, set by the single output register;
//   a new request is taken in the same cycle the held result is taken
// stall: while out_ready is low a held result keeps in_ready low
// config: cfg_wr_en writes cfg_data into register cfg_index at once
//   0 pattern mode, 1 brightness, 2..5 intervals of modes 0..3
//   other indexes are ignored; write only while no request is in flight
// reset: mode 0, brightness 3, all intervals 500, counters and step zero,
//   output empty
module led_chaser_pwm_dimmer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            tick,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lcpd_pkg::LED_W-1:0]      led_drive,
    input  logic                            cfg_wr_en,
    input  logic [lcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcpd_pkg::CFG_W-1:0]      cfg_data
);

    lcpd_pkg::mode_t                 mode_reg;
    logic [lcpd_pkg::BRIGHT_W-1:0]   bright_reg;
    logic [lcpd_pkg::IVAL_W-1:0]     interval_reg [4];
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [lcpd_pkg::LED_W-1:0]      led_reg;
    logic [lcpd_pkg::LED_W-1:0]      led_next;
    logic                            accept;
    lcpd_pkg::view_t                 view;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= lcpd_pkg::MODE_FILL_UP;
            bright_reg      <= lcpd_pkg::BRIGHT_RESET;
            interval_reg[0] <= lcpd_pkg::IVAL_RESET;
            interval_reg[1] <= lcpd_pkg::IVAL_RESET;
            interval_reg[2] <= lcpd_pkg::IVAL_RESET;
            interval_reg[3] <= lcpd_pkg::IVAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lcpd_pkg::REG_PATTERN_MODE:
                    mode_reg <= lcpd_pkg::mode_t'(cfg_data[lcpd_pkg::MODE_W-1:0]);
                lcpd_pkg::REG_BRIGHTNESS:
                    bright_reg <= cfg_data[lcpd_pkg::BRIGHT_W-1:0];
                lcpd_pkg::REG_INTERVAL0: interval_reg[0] <= cfg_data;
                lcpd_pkg::REG_INTERVAL1: interval_reg[1] <= cfg_data;
                lcpd_pkg::REG_INTERVAL2: interval_reg[2] <= cfg_data;
                lcpd_pkg::REG_INTERVAL3: interval_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    lcpd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .tick     (tick),
        .mode     (mode_reg),
        .interval (interval_reg[mode_reg]),
        .view     (view)
    );

    lcpd_pattern u_pattern (
        .mode       (mode_reg),
        .brightness (bright_reg),
        .view       (view),
        .led        (led_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            led_reg <= led_next;
    end

    assign out_valid = out_valid_reg;
    assign led_drive = led_reg;

endmodule

[src/lcpd_seq.sv]
module lcpd_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         tick,
    input  lcpd_pkg::mode_t              mode,
    input  logic [lcpd_pkg::IVAL_W-1:0]  interval,
    output lcpd_pkg::view_t              view
);

    logic [lcpd_pkg::IVAL_W-1:0]  count_reg;
    logic [lcpd_pkg::IVAL_W-1:0]  count_next;
    logic [lcpd_pkg::IVAL_W-1:0]  count_inc;
    logic [lcpd_pkg::PHASE_W-1:0] phase_reg;
    logic [lcpd_pkg::PHASE_W-1:0] phase_next;
    logic [lcpd_pkg::PHASE_W-1:0] phase_inc;
    logic [lcpd_pkg::STEP_W-1:0]  step_reg;
    logic [lcpd_pkg::STEP_W-1:0]  step_adv;
    logic [lcpd_pkg::STEP_W-1:0]  step_next;

    always_comb
    begin
        count_inc  = count_reg + lcpd_pkg::IVAL_W'(1);
        phase_inc  = phase_reg + lcpd_pkg::PHASE_W'(1);
        count_next = count_reg;
        phase_next = phase_reg;
        step_adv   = step_reg;
        view.phase = (phase_reg == '0) ?
                     lcpd_pkg::PHASE_W'(lcpd_pkg::PWM_STEPS) : phase_reg;
        if (tick)
        begin
            if (count_inc >= interval)
            begin
                count_next = '0;
                step_adv   = step_reg + lcpd_pkg::STEP_W'(1);
            end
            else
            begin
                count_next = count_inc;
            end
            view.phase = phase_inc;
            phase_next = (phase_inc >= lcpd_pkg::PHASE_W'(lcpd_pkg::PWM_STEPS)) ?
                         '0 : phase_inc;
        end
        // a step past the end of the current pattern folds back to step 0
        step_next = (step_adv >= lcpd_pkg::steps_of(mode)) ? '0 : step_adv;
        view.step = step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
            step_reg  <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

endmodule

[src/lcpd_pattern.sv]
module lcpd_pattern (
    input  lcpd_pkg::mode_t                mode,
    input  logic [lcpd_pkg::BRIGHT_W-1:0]  brightness,
    input  lcpd_pkg::view_t                view,
    output logic [lcpd_pkg::LED_W-1:0]     led
);

    logic [lcpd_pkg::LED_W-1:0] pattern;
    logic                       blank;

    always_comb
    begin
        unique case (mode)
            lcpd_pkg::MODE_FILL_UP:   pattern = lcpd_pkg::LED_ALL_OFF << view.step;
            lcpd_pkg::MODE_FILL_DOWN: pattern = lcpd_pkg::LED_ALL_OFF >> view.step;
            lcpd_pkg::MODE_CONVERGE:
                pattern = ~((lcpd_pkg::LED_LOW << view.step) |
                            (lcpd_pkg::LED_HIGH >> view.step));
            lcpd_pkg::MODE_DIVERGE:
                pattern = ~((lcpd_pkg::LED_MID_UP << view.step) |
                            (lcpd_pkg::LED_MID_DN >> view.step));
            default:                  pattern = lcpd_pkg::LED_ALL_OFF;
        endcase
        blank = lcpd_pkg::CMP_W'(view.phase) > lcpd_pkg::CMP_W'(brightness);
        led   = blank ? lcpd_pkg::LED_ALL_OFF : pattern;
    end

endmodule

[test/tb_led_chaser_pwm_dimmer.sv]
module tb_led_chaser_pwm_dimmer;

    import lcpd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 125;
    localparam int TICK_PCT     = 75;
    localparam int HOLD_PHASE   = 5;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    class led_drive_board;
        mode_t                mode;
        logic [BRIGHT_W-1:0]  bright;
        logic [IVAL_W-1:0]    ival [4];
        logic [IVAL_W-1:0]    tick_count;
        logic [PHASE_W-1:0]   phase;
        logic [STEP_W-1:0]    step;
        logic [LED_W-1:0]     expected_drive [$];
        int                   requests;
        int                   results;
        int                   mismatches;
        int                   strays;

        function new();
            mode       = MODE_FILL_UP;
            bright     = BRIGHT_RESET;
            foreach (ival[i])
                ival[i] = IVAL_RESET;
            tick_count = '0;
            phase      = '0;
            step       = '0;
            requests   = 0;
            results    = 0;
            mismatches = 0;
            strays     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_PATTERN_MODE: mode = mode_t'(data[MODE_W-1:0]);
                REG_BRIGHTNESS:   bright = data[BRIGHT_W-1:0];
                REG_INTERVAL0, REG_INTERVAL1, REG_INTERVAL2, REG_INTERVAL3:
                    ival[idx - REG_INTERVAL0] = data[IVAL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic t);
            logic [PHASE_W-1:0] shown;
            logic [STEP_W-1:0]  span;
            logic [LED_W-1:0]   drive;
            requests++;
            if (t)
            begin
                tick_count = tick_count + 1'b1;
                if (tick_count >= ival[mode])
                begin
                    tick_count = '0;
                    step       = step + 1'b1;
                end
                phase = phase + 1'b1;
                shown = phase;
                if (phase >= PWM_STEPS)
                    phase = '0;
            end
            else
            begin
                // a stored phase of zero stands for the last phase
                shown = (phase == 0) ? PHASE_W'(PWM_STEPS) : phase;
            end
            span = (mode == MODE_FILL_UP || mode == MODE_FILL_DOWN) ? STEPS_FILL : STEPS_PAIR;
            if (step >= span)
                step = '0;
            case (mode)
                MODE_FILL_UP:   drive = LED_ALL_OFF << step;
                MODE_FILL_DOWN: drive = LED_ALL_OFF >> step;
                MODE_CONVERGE:  drive = ~((LED_LOW << step) | (LED_HIGH >> step));
                default:        drive = ~((LED_MID_UP << step) | (LED_MID_DN >> step));
            endcase
            if (shown > bright)
                drive = LED_ALL_OFF;
            expected_drive.push_back(drive);
        endfunction

        function void check_drive(logic [LED_W-1:0] actual);
            logic [LED_W-1:0] want;
            results++;
            if (expected_drive.size() == 0)
            begin
                strays++;
                if (strays <= 10)
                    $display("unexpected led_drive %02h on result %0d", actual, results);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (want !== actual)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("led_drive mismatch on result %0d: expected %02h, got %02h",
                                 results, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 tick;
    logic                 out_valid;
    logic                 out_ready;
    logic [LED_W-1:0]     led_drive;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    led_drive_board board;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycle_count;
    int cfg_writes;
    int failures;

    led_chaser_pwm_dimmer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tick      (tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .led_drive (led_drive),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_drive(led_drive);
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(input logic t);
        in_valid <= 1'b1;
        tick     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(t);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic random_setup();
        logic [CFG_W-1:0] span;
        set_reg(REG_PATTERN_MODE, CFG_W'($urandom));
        set_reg(REG_BRIGHTNESS, CFG_W'($urandom));
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(9))
                0:       span = '0;
                1:       span = '1;
                2:       span = CFG_W'($urandom);
                default: span = CFG_W'($urandom_range(1, 6));
            endcase
            set_reg(CFG_IDX_W'(REG_INTERVAL0 + i), span);
        end
        if ($urandom_range(3) == 0)
            set_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_request($urandom_range(99) < TICK_PCT);
            if ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < idle_pct);
            end
        end
    endtask

    initial
    begin
        board       = new();
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        cycle_count = 0;
        cfg_writes  = 0;
        rst_n       = 1'b0;
        in_valid  <= 1'b0;
        tick      <= 1'b0;
        out_ready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: refresh at phase zero, then one full pwm cycle
        send_request(1'b0);
        repeat (4) send_request(1'b1);
        send_request(1'b0);
        wait_idle();

        // zero interval steps on every tick, fill up wraps past step 8
        set_reg(REG_BRIGHTNESS, CFG_W'(4));
        set_reg(REG_INTERVAL0, '0);
        cfg_wr_en <= 1'b0;
        repeat (9) send_request(1'b1);
        wait_idle();

        set_reg(REG_PATTERN_MODE, CFG_W'(MODE_CONVERGE));
        set_reg(REG_BRIGHTNESS, '0);
        set_reg(REG_INTERVAL2, '1);
        set_reg(REG_SPARE_LO, '1);
        set_reg(REG_SPARE_HI, CFG_W'(16'h5a5a));
        cfg_wr_en <= 1'b0;
        send_request(1'b1);
        send_request(1'b0);
        wait_idle();

        set_reg(REG_PATTERN_MODE, CFG_W'(MODE_FILL_DOWN));
        set_reg(REG_BRIGHTNESS, CFG_W'(7));
        set_reg(REG_INTERVAL1, CFG_W'(1));
        cfg_wr_en <= 1'b0;
        repeat (3) send_request(1'b1);
        wait_idle();

        set_reg(REG_PATTERN_MODE, CFG_W'(MODE_DIVERGE));
        set_reg(REG_BRIGHTNESS, CFG_W'(5));
        set_reg(REG_INTERVAL3, CFG_W'(2));
        cfg_wr_en <= 1'b0;
        repeat (5) send_request(1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            random_setup();
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            if (p == HOLD_PHASE)
            begin
                // long receiver hold-off while requests keep coming
                idle_pct = 0;
                hold_req++;
            end
            run_phase(PHASE_ITEMS);
        end

        stall_pct = 0;
        wait_idle();
        repeat (4) @(posedge clk);

        failures = board.mismatches + board.strays + board.pending();
        $display("run covered %0d requests, %0d results and %0d register writes",
                 board.requests, board.results, cfg_writes);
        $display("all four patterns, brightness 0 to 7, intervals 0 to 65535, %0d mismatches",
                 board.mismatches + board.strays);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
